[rtl/core/assert_macros.svh]
// Assertion macros used by the biquad unit; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define BQLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define BQLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bqlp_pkg.sv]
// Types and constants of the six-channel biquad low-pass unit.
package bqlp_pkg;

  localparam int CHANNELS     = 6;
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;
  localparam int EXTRA_BITS   = 8;
  localparam int SECT_BITS    = SAMPLE_BITS + EXTRA_BITS;
  localparam int NUM_REGS     = 6;
  localparam int CFG_IDX_BITS = 3;
  localparam int TAPS         = 5;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_S1_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_S1_A1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_S1_A2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_S2_B0 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_S2_A1 = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_S2_A2 = 3'd5;

  localparam logic signed [COEF_BITS-1:0] RST_S1_B0 = 16'sd763;
  localparam logic signed [COEF_BITS-1:0] RST_S1_A1 = -16'sd23826;
  localparam logic signed [COEF_BITS-1:0] RST_S1_A2 = 16'sd9405;
  localparam logic signed [COEF_BITS-1:0] RST_S2_B0 = 16'sd763;
  localparam logic signed [COEF_BITS-1:0] RST_S2_A1 = -16'sd16595;
  localparam logic signed [COEF_BITS-1:0] RST_S2_A2 = 16'sd5072;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SECT_BITS-1:0]   sect_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filt_accel_x;
    logic signed [SAMPLE_BITS-1:0] filt_accel_y;
    logic signed [SAMPLE_BITS-1:0] filt_accel_z;
    logic signed [SAMPLE_BITS-1:0] filt_gyro_x;
    logic signed [SAMPLE_BITS-1:0] filt_gyro_y;
    logic signed [SAMPLE_BITS-1:0] filt_gyro_z;
    logic                          clipped;
  } out_item_t;

endpackage

[rtl/core/bqlp_ifs.sv]
// Valid/ready channel interfaces for samples in and filtered results out.
interface bqlp_in_if import bqlp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bqlp_out_if import bqlp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/six_channel_biquad_lowpass_unit.sv]
// Six-channel fourth-order low-pass (two DF1 biquads per axis) on one shared MAC.
//
//  channel  | dir | payload                              | handshake
//  ---------+-----+--------------------------------------+-------------
//  in_ch    | in  | accel_x/y/z, gyro_x/y/z (16b signed) | valid/ready
//  out_ch   | out | filt_accel_*, filt_gyro_*, clipped   | valid/ready
//  cfg_*    | in  | index 3b, data 16b (Q2.14 coefs)     | write enable
//
// Per sample, each axis runs two sections of five multiply-accumulates on the
// single 17x24 multiplier (plus a step that drains the product register), a
// round/clamp step per section and an output rounding step; the six axes run
// in turn, then the result is loaded. A new sample is accepted only after that
// load: in_ch.ready is high only in idle.
// Reset (rst_n low, synchronous) loads the default coefficients and clears
// all filter histories at once. A stalled result sits in the output register
// while the next sample is accepted and filtered; the load waits until the
// previous result is taken.
module six_channel_biquad_lowpass_unit import bqlp_pkg::*; #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                    clk,
  input  logic                    rst_n,
  bqlp_in_if.sink                 in_ch,
  bqlp_out_if.source              out_ch,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COEF_BITS-1:0]    cfg_data
);

  localparam int CH_W   = $clog2(CHANNELS);
  localparam int TAP_W  = $clog2(TAPS + 1);
  localparam int OP_W   = COEF_BITS + 1;          // b0, 2*b0, -a1, -a2
  localparam int PROD_W = OP_W + SECT_BITS;
  localparam int ACC_W  = PROD_W + 3;             // five products summed
  localparam int RND_W  = ACC_W + 1;
  localparam int SH_W   = RND_W - COEF_FRAC_BITS;
  localparam int ORND_W = SECT_BITS + 1;
  localparam int OSH_W  = ORND_W - EXTRA_BITS;

  localparam logic signed [RND_W-1:0] SECT_HALF =
    RND_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));
  localparam logic signed [SH_W-1:0] SECT_HI =
    SH_W'((64'sd1 <<< (SECT_BITS - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] SECT_LO = -SECT_HI - SH_W'(1);
  localparam logic signed [ORND_W-1:0] OUT_HALF =
    ORND_W'(64'sd1 <<< (EXTRA_BITS - 1));
  localparam logic signed [OSH_W-1:0] OUT_HI =
    OSH_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [OSH_W-1:0] OUT_LO = -OUT_HI - OSH_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SECT,
    S_OUT,
    S_FLUSH
  } state_t;

  // Sequencer and result registers
  state_t             state_r;
  logic [CH_W-1:0]    ch_r;
  logic               sec_r;
  logic [TAP_W-1:0]   t_r;
  logic               clip_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  // Coefficients and filter histories (newer tap 1, older tap 2)
  coef_t   coef_r [NUM_REGS];
  sample_t ih1_r  [CHANNELS];
  sample_t ih2_r  [CHANNELS];
  sect_t   mh1_r  [CHANNELS];
  sect_t   mh2_r  [CHANNELS];
  sect_t   oh1_r  [CHANNELS];
  sect_t   oh2_r  [CHANNELS];

  // Datapath payload
  sample_t                  x_r   [CHANNELS];
  sample_t                  res_r [CHANNELS];
  sect_t                    m_r;
  sect_t                    o_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                     in_accept;
  sample_t                  samp [CHANNELS];
  coef_t                    b0, a1, a2;
  logic signed [OP_W-1:0]   coef_op;
  sect_t                    data_op;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [RND_W-1:0]  rnd;
  logic signed [SH_W-1:0]   sh;
  sect_t                    sect_val;
  logic                     sect_clip;
  logic signed [ORND_W-1:0] ornd;
  logic signed [OSH_W-1:0]  osh;
  sample_t                  out_val;
  logic                     out_clip;
  logic                     last_ch;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign last_ch      = (ch_r == CH_W'(CHANNELS - 1));

  always_comb begin
    samp[0] = in_ch.data.accel_x;
    samp[1] = in_ch.data.accel_y;
    samp[2] = in_ch.data.accel_z;
    samp[3] = in_ch.data.gyro_x;
    samp[4] = in_ch.data.gyro_y;
    samp[5] = in_ch.data.gyro_z;
  end

  // Operand select for the shared multiplier: tap t of section sec_r.
  always_comb begin
    b0 = sec_r ? coef_r[REG_S2_B0] : coef_r[REG_S1_B0];
    a1 = sec_r ? coef_r[REG_S2_A1] : coef_r[REG_S1_A1];
    a2 = sec_r ? coef_r[REG_S2_A2] : coef_r[REG_S1_A2];
    case (t_r)
      TAP_W'(0): coef_op = {b0[COEF_BITS-1], b0};
      TAP_W'(1): coef_op = {b0, 1'b0};
      TAP_W'(2): coef_op = {b0[COEF_BITS-1], b0};
      TAP_W'(3): coef_op = -{a1[COEF_BITS-1], a1};
      TAP_W'(4): coef_op = -{a2[COEF_BITS-1], a2};
      default:   coef_op = '0;
    endcase
    if (!sec_r) begin
      case (t_r)
        TAP_W'(0): data_op = {x_r[ch_r], {EXTRA_BITS{1'b0}}};
        TAP_W'(1): data_op = {ih1_r[ch_r], {EXTRA_BITS{1'b0}}};
        TAP_W'(2): data_op = {ih2_r[ch_r], {EXTRA_BITS{1'b0}}};
        TAP_W'(3): data_op = mh1_r[ch_r];
        TAP_W'(4): data_op = mh2_r[ch_r];
        default:   data_op = '0;
      endcase
    end else begin
      // Section one's history doubles as section two's input history.
      case (t_r)
        TAP_W'(0): data_op = m_r;
        TAP_W'(1): data_op = mh1_r[ch_r];
        TAP_W'(2): data_op = mh2_r[ch_r];
        TAP_W'(3): data_op = oh1_r[ch_r];
        TAP_W'(4): data_op = oh2_r[ch_r];
        default:   data_op = '0;
      endcase
    end
    prod_nxt = coef_op * data_op;
  end

  // Section result: round half up, drop the coefficient fraction, clamp.
  always_comb begin
    rnd       = {acc_r[ACC_W-1], acc_r} + SECT_HALF;
    sh        = rnd[RND_W-1:COEF_FRAC_BITS];
    sect_clip = 1'b0;
    if (sh > SECT_HI) begin
      sect_val  = SECT_HI[SECT_BITS-1:0];
      sect_clip = 1'b1;
    end else if (sh < SECT_LO) begin
      sect_val  = SECT_LO[SECT_BITS-1:0];
      sect_clip = 1'b1;
    end else begin
      sect_val  = sh[SECT_BITS-1:0];
    end
  end

  // Output sample: round off the extra fraction bits, clamp to sample range.
  always_comb begin
    ornd     = {o_r[SECT_BITS-1], o_r} + OUT_HALF;
    osh      = ornd[ORND_W-1:EXTRA_BITS];
    out_clip = 1'b0;
    if (osh > OUT_HI) begin
      out_val  = OUT_HI[SAMPLE_BITS-1:0];
      out_clip = 1'b1;
    end else if (osh < OUT_LO) begin
      out_val  = OUT_LO[SAMPLE_BITS-1:0];
      out_clip = 1'b1;
    end else begin
      out_val  = osh[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer, clip flag and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      sec_r       <= 1'b0;
      t_r         <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Drop the result once taken; the load state sets valid itself.
      if (out_valid_r && out_ch.ready && state_r != S_FLUSH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            ch_r    <= '0;
            sec_r   <= 1'b0;
            t_r     <= '0;
            clip_r  <= 1'b0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          // Issue taps 0..TAPS-1; the last cycle only drains the product.
          if (t_r == TAP_W'(TAPS)) begin
            state_r <= S_SECT;
          end else begin
            t_r <= t_r + TAP_W'(1);
          end
        end
        S_SECT: begin
          clip_r <= clip_r | sect_clip;
          if (!sec_r) begin
            sec_r   <= 1'b1;
            t_r     <= '0;
            state_r <= S_MAC;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          clip_r <= clip_r | out_clip;
          if (last_ch) begin
            state_r <= S_FLUSH;
          end else begin
            ch_r    <= ch_r + CH_W'(1);
            sec_r   <= 1'b0;
            t_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_FLUSH: begin
          // Hold until the previous result has been taken.
          if (!out_valid_r || out_ch.ready) begin
            out_data_r.filt_accel_x <= res_r[0];
            out_data_r.filt_accel_y <= res_r[1];
            out_data_r.filt_accel_z <= res_r[2];
            out_data_r.filt_gyro_x  <= res_r[3];
            out_data_r.filt_gyro_y  <= res_r[4];
            out_data_r.filt_gyro_z  <= res_r[5];
            out_data_r.clipped      <= clip_r;
            out_valid_r             <= 1'b1;
            state_r                 <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Coefficient registers and filter histories.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[REG_S1_B0] <= RST_S1_B0;
      coef_r[REG_S1_A1] <= RST_S1_A1;
      coef_r[REG_S1_A2] <= RST_S1_A2;
      coef_r[REG_S2_B0] <= RST_S2_B0;
      coef_r[REG_S2_A1] <= RST_S2_A1;
      coef_r[REG_S2_A2] <= RST_S2_A2;
      for (int i = 0; i < CHANNELS; i++) begin
        ih1_r[i] <= '0;
        ih2_r[i] <= '0;
        mh1_r[i] <= '0;
        mh2_r[i] <= '0;
        oh1_r[i] <= '0;
        oh2_r[i] <= '0;
      end
    end else begin
      // Drop writes beyond the register list.
      if (cfg_we && (cfg_index < CFG_IDX_BITS'(NUM_REGS))) begin
        coef_r[cfg_index] <= cfg_data;
      end
      // Advance all three histories of the axis once section two is done.
      if (state_r == S_SECT && sec_r) begin
        ih2_r[ch_r] <= ih1_r[ch_r];
        ih1_r[ch_r] <= x_r[ch_r];
        mh2_r[ch_r] <= mh1_r[ch_r];
        mh1_r[ch_r] <= m_r;
        oh2_r[ch_r] <= oh1_r[ch_r];
        oh1_r[ch_r] <= sect_val;
      end
    end
  end

  // Multiply-accumulate and per-axis results.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x_r[i] <= samp[i];
      end
    end
    if (state_r == S_MAC) begin
      prod_r <= prod_nxt;
      if (t_r == '0) begin
        acc_r <= '0;
      end else begin
        acc_r <= acc_r + $signed({{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r});
      end
    end
    if (state_r == S_SECT) begin
      if (!sec_r) begin
        m_r <= sect_val;
      end else begin
        o_r <= sect_val;
      end
    end
    if (state_r == S_OUT) begin
      res_r[ch_r] <= out_val;
    end
  end

`include "assert_macros.svh"

  `BQLP_ASSERT_NEXT(a_busy_after_accept, in_accept, state_r == S_MAC, "no MAC after accept")
  `BQLP_ASSERT_NOW(a_tap_range, state_r == S_MAC, t_r <= TAP_W'(TAPS), "tap counter overran")
  `BQLP_ASSERT_NOW(a_ch_range, state_r != S_IDLE, ch_r < CH_W'(CHANNELS), "axis index overran")
  `BQLP_ASSERT_NOW(a_out_from_flush, $rose(out_valid_r), $past(state_r) == S_FLUSH, "result outside load")

endmodule
